### src/dnsdec_pkg.sv
// Shared types and constants of the DNS name decompressor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package dnsdec_pkg;

  // Command codes of an input beat
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_NEWPKT = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  // Field and walk widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int OFF_W    = 9;
  localparam int CONS_W   = 10;
  localparam int MJ_W     = 6;
  localparam int JUMP_W   = 7;
  // Walk position covers every 14-bit pointer target and the packet length
  localparam int POS_W    = 15;
  localparam int SUM_W    = 16;
  localparam int TGT_W    = 14;

  // Label byte coding
  localparam logic [1:0]        PTR_MARK   = 2'b11;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [MJ_W-1:0]   JUMP_RESET = 6'd20;

  // Register index of max_jumps
  localparam logic REG_MAX_JUMPS = 1'b0;

  // Name buffer control from the walker
  typedef struct packed {
    logic              clear;
    logic              push;
    logic [BYTE_W-1:0] push_char;
    logic              strip;
  } nb_ctrl_t;

endpackage

### src/dnsdec_name_buf.sv
// Name buffer of the DNS name decompressor: character store, fill count
// and trailing-dot strip. Depends on dnsdec_pkg.
`timescale 1ns / 1ps
module dnsdec_name_buf #(
  parameter int NAME_BYTES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dnsdec_pkg::nb_ctrl_t          ctrl_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(NAME_BYTES)-1:0] rd_addr_i,
  output logic [$clog2(NAME_BYTES)-1:0] count_o,
  output logic [7:0]                    rd_data_o
);
  import dnsdec_pkg::*;

  localparam int NC_W = $clog2(NAME_BYTES);
  localparam logic [NC_W-1:0] FULL_CNT = NC_W'(NAME_BYTES - 1);

  logic [BYTE_W-1:0] mem [NAME_BYTES];
  logic [NC_W-1:0]   count_q, count_d;
  logic              last_dot_q, last_dot_d;
  logic [BYTE_W-1:0] rd_data_q;
  logic              wr_en;

  // Keep a character only while there is room for one more
  assign wr_en = ctrl_i.push && (count_q != FULL_CNT);

  always_comb begin
    count_d    = count_q;
    last_dot_d = last_dot_q;
    priority if (ctrl_i.clear) begin
      count_d    = '0;
      last_dot_d = 1'b0;
    end else if (wr_en) begin
      count_d    = count_q + NC_W'(1);
      last_dot_d = (ctrl_i.push_char == CHAR_DOT);
    end else if (ctrl_i.strip && (count_q != '0) && last_dot_q) begin
      count_d    = count_q - NC_W'(1);
    end else begin
      count_d    = count_q;
      last_dot_d = last_dot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      last_dot_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      last_dot_q <= last_dot_d;
    end
  end

  // Store write at the fill count
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q] <= ctrl_i.push_char;
    end
  end

  // Registered read for emission
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign count_o   = count_q;
  assign rd_data_o = rd_data_q;

endmodule

### src/dns_name_decompress_top.sv
// DNS name decompressor top level: packet store, label/pointer walker,
// result sequencing and config port. Depends on dnsdec_pkg, dnsdec_name_buf.
// Append and new-packet beats never raise busy.
// A decode walks one stored byte per cycle from the packet store read port,
// reading each length byte, the label characters and both bytes of each pointer.
// It then gives one character beat per cycle and one final beat; busy drops with the final.
// Reset clears length, fill count, control and max_jumps (to 20); stores are not cleared.
`timescale 1ns / 1ps
module dns_name_decompress_top #(
  parameter int PKT_BYTES  = 512,
  parameter int NAME_BYTES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [dnsdec_pkg::CMD_W-1:0]   cmd_i,
  input  logic [dnsdec_pkg::BYTE_W-1:0]  data_byte_i,
  input  logic [dnsdec_pkg::OFF_W-1:0]   start_offset_i,
  // results
  output logic                           result_strobe_o,
  output logic [dnsdec_pkg::BYTE_W-1:0]  name_char_o,
  output logic                           char_valid_o,
  output logic                           last_o,
  output logic                           status_o,
  output logic [dnsdec_pkg::CONS_W-1:0]  consumed_o
);
  import dnsdec_pkg::*;

  localparam int ADDR_W = $clog2(PKT_BYTES);
  localparam int LEN_W  = $clog2(PKT_BYTES + 1);
  localparam int NC_W   = $clog2(NAME_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PKT_BYTES);

  // Walker states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_PTR   = 3'd3;
  localparam logic [2:0] S_CHR   = 3'd4;
  localparam logic [2:0] S_DOT   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [OFF_W-1:0]  start_q, start_d;
  logic [JUMP_W-1:0] jumps_q, jumps_d;
  logic [BYTE_W-1:0] lb_q, lb_d;
  logic [BYTE_W-1:0] cnt_q, cnt_d;
  logic [CONS_W-1:0] used_q, used_d;
  logic              have_used_q, have_used_d;
  logic [NC_W-1:0]   idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              fin_q, fin_d;
  logic              stat_q, stat_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [MJ_W-1:0]   max_jumps_q;

  logic              accept;
  logic              cfg_wr;
  logic [POS_W-1:0]  len_x;
  logic [POS_W-1:0]  pos_rel;
  logic [POS_W-1:0]  pos_inc;
  logic [SUM_W-1:0]  label_end;
  logic [POS_W-1:0]  target;
  logic [JUMP_W-1:0] jumps_inc;
  logic [BYTE_W-1:0] lb;

  // Packet store
  logic [BYTE_W-1:0] pkt_mem [PKT_BYTES];
  logic [BYTE_W-1:0] pkt_rdata_q;
  logic              pkt_re;
  logic [POS_W-1:0]  pkt_raddr;
  logic              pkt_we;

  // Name buffer link
  nb_ctrl_t          nb_ctrl;
  logic              nb_re;
  logic [NC_W-1:0]   nb_count;
  logic [BYTE_W-1:0] nb_rdata;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Config port: max_jumps at index 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_JUMPS);
  assign prdata = (paddr[2] == REG_MAX_JUMPS) ? {{(32-MJ_W){1'b0}}, max_jumps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_jumps_q <= JUMP_RESET;
    end else if (cfg_wr) begin
      max_jumps_q <= pwdata[MJ_W-1:0];
    end
  end

  // Packet length: append grows it until full, new packet empties it
  assign pkt_we = accept && (cmd_i == CMD_APPEND) && (len_q < LEN_MAX);

  always_comb begin
    len_d = len_q;
    if (pkt_we) begin
      len_d = len_q + LEN_W'(1);
    end else if (accept && (cmd_i == CMD_NEWPKT)) begin
      len_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_we) begin
      pkt_mem[len_q[ADDR_W-1:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_re) begin
      pkt_rdata_q <= pkt_mem[pkt_raddr[ADDR_W-1:0]];
    end
  end

  // Walk arithmetic
  assign lb        = pkt_rdata_q;
  assign len_x     = POS_W'(len_q);
  assign pos_rel   = pos_q - POS_W'(start_q);
  assign pos_inc   = pos_q + POS_W'(1);
  assign label_end = SUM_W'(pos_q) + SUM_W'(1) + SUM_W'(lb);
  assign target    = POS_W'({lb_q[TGT_W-BYTE_W-1:0], pkt_rdata_q});
  assign jumps_inc = jumps_q + JUMP_W'(1);

  // Walker: label bytes, pointers, characters, then emission
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    start_d     = start_q;
    jumps_d     = jumps_q;
    lb_d        = lb_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    have_used_d = have_used_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    fin_d       = 1'b0;
    stat_d      = stat_q;
    pkt_re      = 1'b0;
    pkt_raddr   = pos_q;
    nb_ctrl     = '0;
    nb_re       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_DECODE)) begin
          pos_d         = POS_W'(start_offset_i);
          start_d       = start_offset_i;
          jumps_d       = '0;
          have_used_d   = 1'b0;
          idx_d         = '0;
          nb_ctrl.clear = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (pos_q < len_x) begin
          pkt_re  = 1'b1;
          state_d = S_LEN;
        end else begin
          fin_d   = 1'b1;
          stat_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_LEN: begin
        if (lb == '0) begin
          // terminating zero: done
          if (!have_used_q) begin
            used_d = CONS_W'(pos_rel + POS_W'(1));
          end
          nb_ctrl.strip = 1'b1;
          state_d       = S_EMIT;
        end else if (lb[BYTE_W-1 -: 2] == PTR_MARK) begin
          if (pos_inc >= len_x) begin
            fin_d   = 1'b1;
            stat_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            if (!have_used_q) begin
              used_d      = CONS_W'(pos_rel + POS_W'(2));
              have_used_d = 1'b1;
            end
            lb_d      = lb;
            pkt_re    = 1'b1;
            pkt_raddr = pos_inc;
            state_d   = S_PTR;
          end
        end else begin
          if (label_end > SUM_W'(len_q)) begin
            fin_d   = 1'b1;
            stat_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            pos_d     = pos_inc;
            cnt_d     = lb;
            pkt_re    = 1'b1;
            pkt_raddr = pos_inc;
            state_d   = S_CHR;
          end
        end
      end
      S_PTR: begin
        if ((target >= len_x) || (jumps_inc > JUMP_W'(max_jumps_q))) begin
          fin_d   = 1'b1;
          stat_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d     = target;
          jumps_d   = jumps_inc;
          pkt_re    = 1'b1;
          pkt_raddr = target;
          state_d   = S_LEN;
        end
      end
      S_CHR: begin
        // copy one label character a cycle
        nb_ctrl.push      = 1'b1;
        nb_ctrl.push_char = pkt_rdata_q;
        pos_d             = pos_inc;
        cnt_d             = cnt_q - BYTE_W'(1);
        if (cnt_q != BYTE_W'(1)) begin
          pkt_re    = 1'b1;
          pkt_raddr = pos_inc;
        end else begin
          state_d = S_DOT;
        end
      end
      S_DOT: begin
        nb_ctrl.push      = 1'b1;
        nb_ctrl.push_char = CHAR_DOT;
        if (pos_q < len_x) begin
          pkt_re  = 1'b1;
          state_d = S_LEN;
        end else begin
          fin_d   = 1'b1;
          stat_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (idx_q != nb_count) begin
          nb_re  = 1'b1;
          idx_d  = idx_q + NC_W'(1);
          pend_d = 1'b1;
        end else begin
          fin_d   = 1'b1;
          stat_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      fin_q       <= 1'b0;
      stat_q      <= 1'b0;
      have_used_q <= 1'b0;
      jumps_q     <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      fin_q       <= fin_d;
      stat_q      <= stat_d;
      have_used_q <= have_used_d;
      jumps_q     <= jumps_d;
      idx_q       <= idx_d;
    end
  end

  // Walk payload
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    start_q <= start_d;
    lb_q    <= lb_d;
    cnt_q   <= cnt_d;
    used_q  <= used_d;
  end

  dnsdec_name_buf #(
    .NAME_BYTES(NAME_BYTES)
  ) u_name_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (nb_ctrl),
    .rd_en_i  (nb_re),
    .rd_addr_i(idx_q),
    .count_o  (nb_count),
    .rd_data_o(nb_rdata)
  );

  // Result beats: characters from the name buffer, then the final beat
  assign result_strobe_o = pend_q || fin_q;
  assign name_char_o     = pend_q ? nb_rdata : '0;
  assign char_valid_o    = pend_q;
  assign last_o          = fin_q;
  assign status_o        = fin_q && stat_q;
  assign consumed_o      = (fin_q && !stat_q) ? used_q : '0;

endmodule

### src/dnsdec_checker.sv
// Port-level checks of the DNS name decompressor, bound to the top level.
// Depends on dnsdec_pkg and dns_name_decompress_top.
`timescale 1ns / 1ps
module dnsdec_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic [dnsdec_pkg::CMD_W-1:0]   cmd_i,
  input logic                           result_strobe_o,
  input logic [dnsdec_pkg::BYTE_W-1:0]  name_char_o,
  input logic                           char_valid_o,
  input logic                           last_o,
  input logic                           status_o,
  input logic [dnsdec_pkg::CONS_W-1:0]  consumed_o
);
  import dnsdec_pkg::*;

  // A decode beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_DECODE) |=> busy)
    else $error("decode beat did not raise busy");

  // Append and new-packet beats leave the block idle and give no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i != CMD_DECODE) |=> !busy && !result_strobe_o)
    else $error("non-decode beat stalled or produced a result");

  // A character beat is never the final beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && char_valid_o |-> !last_o && !status_o && (consumed_o == '0))
    else $error("character beat carries final fields");

  // An error final carries no character and no consumed count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && status_o |-> last_o && (consumed_o == '0) && (name_char_o == '0))
    else $error("error beat malformed");

  // Nothing follows a final beat in the next cycle, and busy has dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> !busy ##1 !result_strobe_o)
    else $error("beat after final or busy still high");

endmodule

bind dns_name_decompress_top dnsdec_checker u_dnsdec_checker (.*);
